// ===== design/hgs_pkg.sv =====
`timescale 1ns / 1ps

package hgs_pkg;

	// Default grid capacity.
	localparam int MAX_COLUMNS_DEF = 64;
	localparam int MAX_ROWS_DEF    = 64;

	// Field widths.
	localparam int HEIGHT_W   = 16;
	localparam int INDEX_W    = 8;
	localparam int GRID_W     = 7;
	localparam int BAND_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 56;

	// Difference of two heights, one bit wider than a height.
	localparam int DIFF_W = HEIGHT_W + 1;
	// Difference scaled by the band fractions.
	localparam int PROD_W = DIFF_W + 8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 2'd1;

	// Reset values.
	localparam logic [GRID_W-1:0]          GRID_RESET    = 7'd64;
	localparam logic signed [HEIGHT_W-1:0] LOWEST_RESET  = 16'sd0;
	localparam logic signed [HEIGHT_W-1:0] HIGHEST_RESET = 16'sd1600;
	// Range used when the extremes do not span a positive interval (1.0 in Q12.4).
	localparam logic signed [DIFF_W-1:0]   UNIT_RANGE    = 17'sd16;

	// Band thresholds as exact fractions of BAND_SCALE.
	localparam int BAND_SCALE = 100;
	localparam int FRAC_SAND  = 20;
	localparam int FRAC_GRASS = 35;
	localparam int FRAC_ROCK  = 65;
	localparam int FRAC_SNOW  = 85;

	// Elevation band codes.
	localparam logic [BAND_W-1:0] BAND_WATER = 3'd0;
	localparam logic [BAND_W-1:0] BAND_SAND  = 3'd1;
	localparam logic [BAND_W-1:0] BAND_GRASS = 3'd2;
	localparam logic [BAND_W-1:0] BAND_ROCK  = 3'd3;
	localparam logic [BAND_W-1:0] BAND_SNOW  = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_wr;
		logic capture;
		logic lookup;
		logic range;
		logic emit;
	} hgs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic out_free;
	} hgs_sts_t;

endpackage

// ===== design/hgs_ctrl.sv =====
`timescale 1ns / 1ps

module hgs_ctrl import hgs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output hgs_cmd_t cmd,
	input  hgs_sts_t sts
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_RANGE,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   ready_q;

	// State register with the registered ready output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ready_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clear_last) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_LOOKUP;
						ready_q <= 1'b0;
					end
				end
				ST_LOOKUP: state_q <= ST_RANGE;
				ST_RANGE:  state_q <= ST_EMIT;
				ST_EMIT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
					ready_q <= 1'b0;
				end
			endcase
		end
	end

	assign s_tready = ready_q;

	// Decode the datapath commands from the current state.
	always_comb begin
		cmd = '0;
		cmd.capture = s_tvalid && ready_q;
		unique case (state_q)
			ST_CLEAR:  cmd.clear_wr = 1'b1;
			ST_LOOKUP: cmd.lookup = 1'b1;
			ST_RANGE:  cmd.range = 1'b1;
			ST_EMIT:   cmd.emit = sts.out_free;
			default:   ;
		endcase
	end

endmodule

// ===== design/hgs_datapath.sv =====
`timescale 1ns / 1ps

module hgs_datapath import hgs_pkg::*; #(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hgs_cmd_t             cmd,
	output hgs_sts_t             sts,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GRID_W-1:0]    cfg_data,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tuser
);

	localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// Row times column count plus column; both counts stay below 128.
	localparam int LIN_W  = 2 * GRID_W;
	localparam int PAD_W  = M_TDATA_W - (3 * HEIGHT_W + BAND_W);

	logic [GRID_W-1:0]          grid_cols_q;
	logic [GRID_W-1:0]          grid_rows_q;
	logic [GRID_W-1:0]          eff_cols;
	logic [GRID_W-1:0]          eff_rows;

	logic                       mode_q;
	logic signed [INDEX_W-1:0]  col_q;
	logic signed [INDEX_W-1:0]  row_q;
	logic signed [HEIGHT_W-1:0] height_q;

	logic                       in_grid;
	logic [LIN_W-1:0]           lin_addr;
	logic [ADDR_W-1:0]          mem_addr;
	logic [ADDR_W-1:0]          clr_cnt_q;
	logic                       wr_en;
	logic signed [HEIGHT_W-1:0] wr_data;
	logic signed [HEIGHT_W-1:0] mem_q [DEPTH];
	logic signed [HEIGHT_W-1:0] rdata_q;

	logic signed [HEIGHT_W-1:0] lowest_q;
	logic signed [HEIGHT_W-1:0] highest_q;
	logic                       inside_q;

	logic signed [HEIGHT_W-1:0] cell_sel;
	logic signed [DIFF_W-1:0]   diff_c;
	logic signed [DIFF_W-1:0]   range_c;
	logic signed [HEIGHT_W-1:0] cell_q;
	logic signed [DIFF_W-1:0]   diff_q;
	logic signed [DIFF_W-1:0]   range_q;

	logic signed [PROD_W-1:0]   d_scaled;
	logic signed [PROD_W-1:0]   r_sand;
	logic signed [PROD_W-1:0]   r_grass;
	logic signed [PROD_W-1:0]   r_rock;
	logic signed [PROD_W-1:0]   r_snow;
	logic [BAND_W-1:0]          band;

	logic                       out_valid_q;
	logic signed [HEIGHT_W-1:0] out_cell_q;
	logic                       out_inside_q;
	logic [BAND_W-1:0]          out_band_q;
	logic signed [HEIGHT_W-1:0] out_lowest_q;
	logic signed [HEIGHT_W-1:0] out_highest_q;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= GRID_RESET;
			grid_rows_q <= GRID_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GRID_COLUMNS: grid_cols_q <= cfg_data;
				REG_GRID_ROWS:    grid_rows_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Effective grid size is the register clipped to the store capacity.
	assign eff_cols = (int'(grid_cols_q) < MAX_COLUMNS) ? grid_cols_q : GRID_W'(MAX_COLUMNS);
	assign eff_rows = (int'(grid_rows_q) < MAX_ROWS) ? grid_rows_q : GRID_W'(MAX_ROWS);

	// Input item capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q   <= s_tuser;
			col_q    <= s_tdata[INDEX_W-1:0];
			row_q    <= s_tdata[2*INDEX_W-1:INDEX_W];
			height_q <= s_tdata[2*INDEX_W+HEIGHT_W-1:2*INDEX_W];
		end
	end

	// Bounds check and linear address. A negative index has its sign bit set.
	assign in_grid = !col_q[INDEX_W-1] && (col_q[INDEX_W-2:0] < eff_cols)
		&& !row_q[INDEX_W-1] && (row_q[INDEX_W-2:0] < eff_rows);
	assign lin_addr = LIN_W'(row_q[INDEX_W-2:0]) * LIN_W'(eff_cols)
		+ LIN_W'(col_q[INDEX_W-2:0]);

	// Memory port is shared by the clearing sweep and item accesses.
	assign mem_addr = cmd.clear_wr ? clr_cnt_q : ADDR_W'(lin_addr);
	assign wr_en    = cmd.clear_wr || (cmd.lookup && in_grid && mode_q);
	assign wr_data  = cmd.clear_wr ? '0 : height_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[mem_addr] <= wr_data;
		end
		rdata_q <= mem_q[mem_addr];
	end

	// Clearing sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign sts.clear_last = (clr_cnt_q == ADDR_W'(DEPTH - 1));

	// Running extremes widen only on an in-bounds write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_q  <= LOWEST_RESET;
			highest_q <= HIGHEST_RESET;
		end else if (cmd.lookup && in_grid && mode_q) begin
			if (height_q < lowest_q) begin
				lowest_q <= height_q;
			end
			if (height_q > highest_q) begin
				highest_q <= height_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			inside_q <= in_grid;
		end
	end

	// Height of the item, then its offset and the span of the extremes.
	always_comb begin
		if (!inside_q) begin
			cell_sel = '0;
		end else if (mode_q) begin
			cell_sel = height_q;
		end else begin
			cell_sel = rdata_q;
		end
		diff_c  = DIFF_W'(cell_sel) - DIFF_W'(lowest_q);
		range_c = DIFF_W'(highest_q) - DIFF_W'(lowest_q);
		if (range_c <= 0) begin
			range_c = UNIT_RANGE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.range) begin
			cell_q  <= cell_sel;
			diff_q  <= diff_c;
			range_q <= range_c;
		end
	end

	// Band by cross-multiplied fraction compares.
	always_comb begin
		d_scaled = PROD_W'(diff_q) * PROD_W'(BAND_SCALE);
		r_sand   = PROD_W'(range_q) * PROD_W'(FRAC_SAND);
		r_grass  = PROD_W'(range_q) * PROD_W'(FRAC_GRASS);
		r_rock   = PROD_W'(range_q) * PROD_W'(FRAC_ROCK);
		r_snow   = PROD_W'(range_q) * PROD_W'(FRAC_SNOW);
		if (diff_q < 0) begin
			band = BAND_WATER;
		end else if (diff_q >= range_q) begin
			band = BAND_SNOW;
		end else if (d_scaled < r_sand) begin
			band = BAND_WATER;
		end else if (d_scaled < r_grass) begin
			band = BAND_SAND;
		end else if (d_scaled < r_rock) begin
			band = BAND_GRASS;
		end else if (d_scaled < r_snow) begin
			band = BAND_ROCK;
		end else begin
			band = BAND_SNOW;
		end
	end

	// Output register; it frees up as the downstream side takes the item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_cell_q    <= cell_q;
			out_inside_q  <= inside_q;
			out_band_q    <= band;
			out_lowest_q  <= lowest_q;
			out_highest_q <= highest_q;
		end
	end

	assign sts.out_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_inside_q;
	assign m_tdata  = {PAD_W'(0), out_highest_q, out_lowest_q, out_band_q, out_cell_q};

endmodule

// ===== design/height_grid_store_with_banding.sv =====
`timescale 1ns / 1ps

// Height grid store with elevation banding. Holds a MAX_COLUMNS x MAX_ROWS grid
// of signed Q12.4 heights plus a running minimum and maximum (0 and 100.0 after
// reset) that widen on every in-bounds write. Each item reads or writes one cell
// (s_tuser high writes) and returns one item with the cell height, the in-bounds
// flag, an elevation band from 0 to 4 and the extremes after the item. After
// reset the block sweeps the single-port grid memory to zero, one cell a cycle,
// over all MAX_COLUMNS * MAX_ROWS cells (4096 at the defaults) before s_tready
// rises; configuration writes are taken at any time. An item then passes through
// a memory access and a range step, each ending in a register, and a band step
// that loads its result into the output register. s_tready rises again as the
// result is loaded, so the block takes no new item before it is through with
// the last one. The next item is accepted while a finished result still waits;
// it then holds in the band step until the output register frees.
module height_grid_store_with_banding import hgs_pkg::*; #(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Input item.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // column_index[7:0], row_index[15:8],
	                                        // new_height[31:16]
	input  logic                 s_tuser,   // mode
	// Result item.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // cell_height[15:0], elevation_band[18:16],
	                                        // lowest_seen[34:19], highest_seen[50:35]
	output logic                 m_tuser,   // in_bounds
	// Configuration writes.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GRID_W-1:0]    cfg_data
);

	hgs_cmd_t cmd;
	hgs_sts_t sts;

	hgs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	hgs_datapath #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

`ifndef NO_ASSERTIONS
	// No item is taken while the clearing sweep owns the memory.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.clear_wr |-> !s_tready)
		else $error("item accepted during clearing sweep");

	// Extremes only widen from their reset values.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[34:19]) <= LOWEST_RESET)
			&& ($signed(m_tdata[50:35]) >= HIGHEST_RESET))
		else $error("running extremes narrowed");

	// An out-of-bounds result carries height zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[15:0] == '0))
		else $error("out-of-bounds result with nonzero height");

	// Band code stays within water to snow.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[18:16] <= BAND_SNOW))
		else $error("elevation band out of range");

	// One item at a time: acceptance drops ready on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item accepted while one is in progress");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import hgs_pkg::*;

	// Item modes and the register indexes that the block does not decode.
	localparam logic MODE_READ  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam int GRID_CELLS  = MAX_COLUMNS_DEF * MAX_ROWS_DEF;
	localparam int STALL_LIMIT = 20000;
	localparam int PHASE_ITEMS = 150;
	localparam int NUM_PHASES  = 9;

	// One result item, split into its fields.
	typedef struct packed {
		logic signed [HEIGHT_W-1:0] height;
		logic                       inb;
		logic [BAND_W-1:0]          band;
		logic signed [HEIGHT_W-1:0] lowest;
		logic signed [HEIGHT_W-1:0] highest;
	} grid_result_t;

	// One row of the directed stimulus; known marks a row whose result is typed in.
	typedef struct packed {
		logic                      mode;
		logic signed [INDEX_W-1:0] col;
		logic signed [INDEX_W-1:0] row;
		logic signed [HEIGHT_W-1:0] hgt;
		logic                      known;
		grid_result_t              res;
	} grid_vector_t;

	localparam grid_result_t AFTER_RESET_IN  =
		'{16'sd0, 1'b1, BAND_WATER, LOWEST_RESET, HIGHEST_RESET};
	localparam grid_result_t AFTER_RESET_OUT =
		'{16'sd0, 1'b0, BAND_WATER, LOWEST_RESET, HIGHEST_RESET};

	localparam int NUM_VECTORS = 19;
	localparam grid_vector_t grid_vectors [NUM_VECTORS] = '{
		'{MODE_READ,  8'sd0,    8'sd0,    16'sd0,      1'b1, AFTER_RESET_IN},
		'{MODE_READ,  8'sd63,   8'sd63,   16'sd0,      1'b1, AFTER_RESET_IN},
		'{MODE_READ,  8'sd64,   8'sd0,    16'sd0,      1'b1, AFTER_RESET_OUT},
		'{MODE_READ,  8'sd0,    8'sd64,   16'sd0,      1'b1, AFTER_RESET_OUT},
		'{MODE_READ,  -8'sd1,   8'sd0,    16'sd0,      1'b1, AFTER_RESET_OUT},
		'{MODE_READ,  8'sd0,    -8'sd128, 16'sd0,      1'b1, AFTER_RESET_OUT},
		'{MODE_WRITE, 8'sd127,  8'sd127,  16'sd32767,  1'b1, AFTER_RESET_OUT},
		'{MODE_WRITE, -8'sd128, 8'sd3,    -16'sd32768, 1'b1, AFTER_RESET_OUT},
		'{MODE_WRITE, 8'sd1,    8'sd0,    16'sd1600,   1'b0, '0},
		'{MODE_WRITE, 8'sd2,    8'sd0,    16'sd320,    1'b0, '0},
		'{MODE_WRITE, 8'sd3,    8'sd0,    16'sd319,    1'b0, '0},
		'{MODE_WRITE, 8'sd0,    8'sd0,    16'sd32767,  1'b0, '0},
		'{MODE_WRITE, 8'sd63,   8'sd63,   -16'sd32768, 1'b0, '0},
		'{MODE_READ,  8'sd0,    8'sd0,    16'sd0,      1'b0, '0},
		'{MODE_READ,  8'sd63,   8'sd63,   16'sd0,      1'b0, '0},
		'{MODE_READ,  8'sd1,    8'sd0,    16'sd0,      1'b0, '0},
		'{MODE_WRITE, 8'sd5,    8'sd5,    16'h5555,    1'b0, '0},
		'{MODE_WRITE, 8'sd6,    8'sd5,    16'hAAAA,    1'b0, '0},
		'{MODE_READ,  8'sd5,    8'sd5,    16'sd0,      1'b0, '0}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [GRID_W-1:0]    cfg_data;

	// Shadow copy of the grid, the extremes and the size registers.
	logic signed [HEIGHT_W-1:0] shadow_heights [GRID_CELLS];
	logic signed [HEIGHT_W-1:0] shadow_lowest;
	logic signed [HEIGHT_W-1:0] shadow_highest;
	logic [GRID_W-1:0]          shadow_columns;
	logic [GRID_W-1:0]          shadow_rows;

	grid_result_t pending_results [$];
	int           mismatches;
	int           results_seen;
	int           idle_cycles;
	int           burst_left;

	height_grid_store_with_banding DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Band of a height between the extremes, by exact integer comparison.
	function automatic logic [BAND_W-1:0] band_for(int h, int lo, int hi);
		int span;
		int delta;
		span = hi - lo;
		delta = h - lo;
		if (span <= 0) span = UNIT_RANGE;
		if (delta < 0) return BAND_WATER;
		if (delta >= span) return BAND_SNOW;
		if (delta * BAND_SCALE < span * FRAC_SAND) return BAND_WATER;
		if (delta * BAND_SCALE < span * FRAC_GRASS) return BAND_SAND;
		if (delta * BAND_SCALE < span * FRAC_ROCK) return BAND_GRASS;
		if (delta * BAND_SCALE < span * FRAC_SNOW) return BAND_ROCK;
		return BAND_SNOW;
	endfunction

	function automatic int used_columns();
		return (shadow_columns < MAX_COLUMNS_DEF) ? int'(shadow_columns) : MAX_COLUMNS_DEF;
	endfunction

	function automatic int used_rows();
		return (shadow_rows < MAX_ROWS_DEF) ? int'(shadow_rows) : MAX_ROWS_DEF;
	endfunction

	// Apply one accepted access to the shadow grid and work out its result.
	task automatic grid_access(input logic mode, input logic signed [INDEX_W-1:0] col,
			input logic signed [INDEX_W-1:0] row, input logic signed [HEIGHT_W-1:0] hgt,
			output grid_result_t res);
		int c;
		int r;
		int addr;
		logic in_grid;
		logic signed [HEIGHT_W-1:0] value;
		c = col;
		r = row;
		in_grid = (c >= 0) && (c < used_columns()) && (r >= 0) && (r < used_rows());
		value = '0;
		if (in_grid) begin
			addr = (r * used_columns() + c) % GRID_CELLS;
			if (mode == MODE_WRITE) begin
				shadow_heights[addr] = hgt;
				if (hgt < shadow_lowest) shadow_lowest = hgt;
				if (hgt > shadow_highest) shadow_highest = hgt;
				value = hgt;
			end else begin
				value = shadow_heights[addr];
			end
		end
		res.height  = value;
		res.inb     = in_grid;
		res.band    = band_for(value, shadow_lowest, shadow_highest);
		res.lowest  = shadow_lowest;
		res.highest = shadow_highest;
	endtask

	// Offer one item, wait until it is taken, then record what it should produce.
	task automatic send_access(input logic mode, input logic signed [INDEX_W-1:0] col,
			input logic signed [INDEX_W-1:0] row, input logic signed [HEIGHT_W-1:0] hgt,
			input logic known, input grid_result_t known_res);
		grid_result_t res;
		s_tvalid <= 1'b1;
		s_tdata  <= {hgt, row, col};
		s_tuser  <= mode;
		do @(posedge clk); while (!s_tready);
		grid_access(mode, col, row, hgt, res);
		pending_results.push_back(known ? known_res : res);
	endtask

	// Sender pacing: bursts of random length, random gaps between them.
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GRID_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_GRID_COLUMNS) shadow_columns = val;
		else if (idx == REG_GRID_ROWS) shadow_rows = val;
	endtask

	// Stop offering and let every expected result come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic compare_field(input string name, input logic [HEIGHT_W-1:0] want,
			input logic [HEIGHT_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
		end
	endtask

	// Receiver: checks each result item and stalls on a pattern of its own, with one
	// long hold-off so that the block fills up and stops taking items.
	initial begin : result_sink
		int cyc;
		int hold;
		bit squeezed;
		grid_result_t want;
		grid_result_t got;
		cyc = 0;
		hold = 0;
		squeezed = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = {m_tdata[15:0], m_tuser, m_tdata[18:16], m_tdata[34:19], m_tdata[50:35]};
				results_seen++;
				if (pending_results.size() == 0) begin
					mismatches++;
					$display("%0t: result with nothing expected, got %h", $time, got);
				end else begin
					want = pending_results.pop_front();
					compare_field("cell_height", want.height, got.height);
					compare_field("in_bounds", HEIGHT_W'(want.inb), HEIGHT_W'(got.inb));
					compare_field("elevation_band", HEIGHT_W'(want.band),
						HEIGHT_W'(got.band));
					compare_field("lowest_seen", want.lowest, got.lowest);
					compare_field("highest_seen", want.highest, got.highest);
					compare_field("tdata padding", '0, HEIGHT_W'(m_tdata[M_TDATA_W-1:51]));
				end
			end
			cyc++;
			if (!squeezed && results_seen == 250) begin
				squeezed = 1;
				hold = 400;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				case ((cyc / 97) % 5)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 0);
					2: m_tready <= ($urandom_range(0, 9) != 0);
					3: m_tready <= cyc[0];
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Watchdog on cycles in which no handshake completes.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int i;
		int p;
		int k;
		int span_c;
		int span_r;
		int sel;
		int frac;
		int sizes [NUM_PHASES][2];
		logic mode;
		logic signed [INDEX_W-1:0] col;
		logic signed [INDEX_W-1:0] row;
		logic signed [HEIGHT_W-1:0] hgt;

		burst_left = 0;
		for (i = 0; i < GRID_CELLS; i++) shadow_heights[i] = '0;
		shadow_lowest  = LOWEST_RESET;
		shadow_highest = HIGHEST_RESET;
		shadow_columns = GRID_RESET;
		shadow_rows    = GRID_RESET;

		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= MODE_READ;
		cfg_valid <= 1'b0;
		cfg_index <= REG_GRID_COLUMNS;
		cfg_data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset grid size.
		for (i = 0; i < NUM_VECTORS; i++) begin
			send_access(grid_vectors[i].mode, grid_vectors[i].col, grid_vectors[i].row,
				grid_vectors[i].hgt, grid_vectors[i].known, grid_vectors[i].res);
			pace_sender();
		end
		drain();

		// Grid sizes per phase: smallest, zero counts, above capacity, full, mixed.
		sizes = '{'{1, 1}, '{0, 7}, '{5, 0}, '{127, 127}, '{64, 64}, '{13, 50},
			'{64, 1}, '{1, 64}, '{100, 3}};
		sizes[5][0] = $urandom_range(1, 127);

		for (p = 0; p < NUM_PHASES; p++) begin
			write_reg(REG_GRID_COLUMNS, GRID_W'(sizes[p][0]));
			write_reg(REG_GRID_ROWS, GRID_W'(sizes[p][1]));
			write_reg((p % 2 == 0) ? REG_SPARE_A : REG_SPARE_B,
				GRID_W'($urandom_range(0, 127)));
			cfg_valid <= 1'b0;
			@(posedge clk);
			span_c = (used_columns() > 0) ? used_columns() : 1;
			span_r = (used_rows() > 0) ? used_rows() : 1;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				// Mostly cells inside the grid, some at its edges, a few anywhere.
				sel = $urandom_range(0, 9);
				if (sel < 7) begin
					col = INDEX_W'($urandom_range(0, span_c - 1));
					row = INDEX_W'($urandom_range(0, span_r - 1));
				end else if (sel < 9) begin
					col = INDEX_W'(span_c - 2 + $urandom_range(0, 2));
					row = INDEX_W'(span_r - 2 + $urandom_range(0, 2));
				end else begin
					col = INDEX_W'($urandom);
					row = INDEX_W'($urandom);
				end
				mode = 1'($urandom_range(0, 1));
				// Heights: full range, right at the band thresholds, or near zero.
				case ($urandom_range(0, 3))
					0, 1: hgt = HEIGHT_W'($urandom);
					2: begin
						case ($urandom_range(0, 3))
							0: frac = FRAC_SAND;
							1: frac = FRAC_GRASS;
							2: frac = FRAC_ROCK;
							default: frac = FRAC_SNOW;
						endcase
						hgt = HEIGHT_W'(-32768 + (65535 * frac) / BAND_SCALE
							+ $urandom_range(0, 2) - 1);
					end
					default: hgt = HEIGHT_W'($urandom_range(0, 4000) - 2000);
				endcase
				send_access(mode, col, row, hgt, 1'b0, '0);
				pace_sender();
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
